[hdl/cft_pkg.sv]
// Package for the CSV field tokeniser: character codes, byte classes,
// parse phases, queue item type and configuration register map. No dependencies.
package cft_pkg;

  // Character codes that the parser reacts to
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  // Configuration defaults and register map
  localparam logic [7:0] FieldLimitReset   = 8'd255;
  localparam int unsigned CfgAddrWidth     = 3;
  localparam logic        RegFieldLimit    = 1'b0;

  // Depth of the queue between classifier and parser
  localparam int unsigned QueueDepthDefault = 2;

  // Class of one input byte, decided by the front end
  typedef enum logic [2:0] {
    CL_TERM,
    CL_QUOTE,
    CL_COMMA,
    CL_BLANK,
    CL_EOL,
    CL_OTHER
  } char_class_e;

  // Parser phase within a line
  typedef enum logic [2:0] {
    PH_START,
    PH_START_BLANK,
    PH_QUOTED,
    PH_UNQUOTED,
    PH_POSTQUOTE,
    PH_STOPPED
  } parse_phase_e;

  // One classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0]  char_byte;
    char_class_e cls;
  } queue_item_t;

endpackage

[hdl/cft_front.sv]
// Front end of the CSV field tokeniser: accepts input bytes and classifies them.
// Depends on cft_pkg.
module cft_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_byte_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output cft_pkg::queue_item_t push_item_o
);
  import cft_pkg::*;

  char_class_e cls;

  // Sort the byte into the classes the parser distinguishes
  always_comb begin
    case (char_byte_i)
      CharNul:          cls = CL_TERM;
      CharQuote:        cls = CL_QUOTE;
      CharComma:        cls = CL_COMMA;
      CharSpace, CharTab: cls = CL_BLANK;
      CharLf, CharCr:   cls = CL_EOL;
      default:          cls = CL_OTHER;
    endcase
  end

  // The request goes straight into the queue when it has room
  assign push_valid_o          = in_valid_i;
  assign in_ready_o            = push_ready_i;
  assign push_item_o.char_byte = char_byte_i;
  assign push_item_o.cls       = cls;

endmodule

[hdl/cft_queue.sv]
// Short register queue between the classifier and the parser of the CSV
// field tokeniser. Depends on cft_pkg.
module cft_queue #(
  parameter int unsigned Depth = cft_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  cft_pkg::queue_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output cft_pkg::queue_item_t pop_item_o
);
  import cft_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(Depth);

  queue_item_t         entries_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntWidth'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/cft_back.sv]
// Back end of the CSV field tokeniser: parse state machine and output register.
// Depends on cft_pkg.
module cft_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           field_limit_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  cft_pkg::queue_item_t pop_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 content_valid_o,
  output logic [7:0]           content_byte_o,
  output logic [7:0]           field_index_o,
  output logic                 field_end_o,
  output logic                 line_done_o,
  output logic [7:0]           field_total_o
);
  import cft_pkg::*;

  parse_phase_e phase_q, phase_d;
  logic [7:0]   fields_q, fields_d;
  logic [7:0]   fields_inc;
  logic         do_pop;
  logic         out_valid_q;

  logic       cv_d, fe_d, ld_d;
  logic [7:0] cb_d, fi_d, ft_d;
  logic       cv_q, fe_q, ld_q;
  logic [7:0] cb_q, fi_q, ft_q;

  char_class_e cls;
  logic [7:0]  ch;

  assign cls        = pop_item_i.cls;
  assign ch         = pop_item_i.char_byte;
  assign fields_inc = fields_q + 8'd1;

  // A new request is taken whenever the output register is free or draining
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign do_pop      = pop_valid_i && pop_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      fields_q <= '0;
    end else if (do_pop) begin
      phase_q  <= phase_d;
      fields_q <= fields_d;
    end
  end

  // Next state and result for the byte at the head of the queue
  always_comb begin
    phase_d  = phase_q;
    fields_d = fields_q;
    cv_d     = 1'b0;
    cb_d     = '0;
    fi_d     = '0;
    fe_d     = 1'b0;
    ld_d     = 1'b0;
    ft_d     = '0;
    if (cls == CL_TERM) begin
      // The terminator closes any open field and reports the count
      ld_d = 1'b1;
      if (phase_q == PH_QUOTED || phase_q == PH_UNQUOTED ||
          (phase_q == PH_START_BLANK && fields_q < field_limit_i)) begin
        fe_d = 1'b1;
        fi_d = fields_q;
        ft_d = fields_inc;
      end else begin
        ft_d = fields_q;
      end
      phase_d  = PH_START;
      fields_d = '0;
    end else begin
      case (phase_q)
        PH_QUOTED: begin
          if (cls == CL_QUOTE) begin
            fe_d     = 1'b1;
            fi_d     = fields_q;
            fields_d = fields_inc;
            phase_d  = PH_POSTQUOTE;
          end else begin
            cv_d = 1'b1;
            cb_d = ch;
            fi_d = fields_q;
          end
        end
        PH_UNQUOTED: begin
          if (cls == CL_COMMA || cls == CL_EOL) begin
            fe_d     = 1'b1;
            fi_d     = fields_q;
            fields_d = fields_inc;
            phase_d  = PH_START;
          end else begin
            cv_d = 1'b1;
            cb_d = ch;
            fi_d = fields_q;
          end
        end
        PH_START, PH_START_BLANK, PH_POSTQUOTE: begin
          if (fields_q >= field_limit_i) begin
            phase_d = PH_STOPPED;
          end else if (phase_q == PH_POSTQUOTE &&
                       (cls == CL_COMMA || cls == CL_BLANK)) begin
            // Separators after a closing quote are skipped
            phase_d = PH_POSTQUOTE;
          end else begin
            case (cls)
              CL_BLANK: phase_d = PH_START_BLANK;
              CL_QUOTE: phase_d = PH_QUOTED;
              CL_COMMA: begin
                fe_d     = 1'b1;
                fi_d     = fields_q;
                fields_d = fields_inc;
                phase_d  = PH_START;
              end
              CL_EOL: begin
                fe_d     = 1'b1;
                fi_d     = fields_q;
                fields_d = fields_inc;
                phase_d  = PH_STOPPED;
              end
              default: begin
                cv_d    = 1'b1;
                cb_d    = ch;
                fi_d    = fields_q;
                phase_d = PH_UNQUOTED;
              end
            endcase
          end
        end
        default: phase_d = PH_STOPPED;
      endcase
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      cv_q <= cv_d;
      cb_q <= cb_d;
      fi_q <= fi_d;
      fe_q <= fe_d;
      ld_q <= ld_d;
      ft_q <= ft_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign content_valid_o = cv_q;
  assign content_byte_o  = cb_q;
  assign field_index_o   = fi_q;
  assign field_end_o     = fe_q;
  assign line_done_o     = ld_q;
  assign field_total_o   = ft_q;

  // A byte is either content or a field end, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(cv_q && fe_q))
    else $error("content and field end on the same result");

  // The field count is only reported with the line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ld_q) |-> (ft_q == 8'd0))
    else $error("field total outside line end");

  // A terminator always returns the parser to line start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && cls == CL_TERM) |=> (phase_q == PH_START && fields_q == 8'd0))
    else $error("parser not back at line start after terminator");

  // Content is never the terminator byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cv_q) |-> (cb_q != CharNul))
    else $error("terminator reported as content");

endmodule

[hdl/csv_field_tokenizer.sv]
// Top level of the CSV field tokeniser: configuration register, classifier,
// queue and parser. Depends on cft_pkg, cft_front, cft_queue and cft_back.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_ready_o  char_byte_i
//   result    out        out_valid_o/out_ready_i content_valid_o .. field_total_o
//   config    in         psel/penable/pwrite    paddr_i, pwdata_i, prdata_o
//
// One byte is taken per cycle while the queue has room, and one result leaves per
// cycle while out_ready_i is high. A result reaches the outputs through registers:
// the byte is first written into the queue, then into the parser output register.
// The parser decides each byte combinationally.
// Reset returns the parser to line start with no fields counted and sets the
// field limit to 255. A stalled output fills the queue; input ready falls
// once the queue is full, and each side resumes independently.
module csv_field_tokenizer #(
  parameter int unsigned QueueDepth = cft_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [cft_pkg::CfgAddrWidth-1:0] paddr_i,
  input  logic [31:0]                      pwdata_i,
  output logic [31:0]                      prdata_o,
  output logic                             pready_o,
  // Input bytes
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       char_byte_i,
  // Results
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             content_valid_o,
  output logic [7:0]                       content_byte_o,
  output logic [7:0]                       field_index_o,
  output logic                             field_end_o,
  output logic                             line_done_o,
  output logic [7:0]                       field_total_o
);
  import cft_pkg::*;

  logic        field_limit_wr;
  logic [7:0]  field_limit_q;
  logic        reg_sel;

  logic        push_valid, push_ready;
  queue_item_t push_item;
  logic        pop_valid, pop_ready;
  queue_item_t pop_item;

  // Configuration register: field limit at word address zero
  assign reg_sel        = paddr_i[CfgAddrWidth-1];
  assign pready_o       = 1'b1;
  assign field_limit_wr = psel_i && penable_i && pwrite_i && (reg_sel == RegFieldLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_limit_q <= FieldLimitReset;
    end else if (field_limit_wr) begin
      field_limit_q <= pwdata_i[7:0];
    end
  end

  assign prdata_o = (reg_sel == RegFieldLimit) ? {24'd0, field_limit_q} : 32'd0;

  // Classifier
  cft_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  // Queue between classifier and parser
  cft_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  // Parser and output register
  cft_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .field_limit_i  (field_limit_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .content_valid_o(content_valid_o),
    .content_byte_o (content_byte_o),
    .field_index_o  (field_index_o),
    .field_end_o    (field_end_o),
    .line_done_o    (line_done_o),
    .field_total_o  (field_total_o)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for csv_field_tokenizer: drives text lines byte by byte,
// predicts every result in-line and compares it against the block's output.
// Depends on cft_pkg and the csv_field_tokenizer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cft_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrinted = 30;
  localparam logic [CfgAddrWidth-1:0] FieldLimitAddr = CfgAddrWidth'(4 * RegFieldLimit);

  // One result of the tokeniser, field for field as on the ports
  typedef struct packed {
    logic       content_valid;
    logic [7:0] content_byte;
    logic [7:0] field_index;
    logic       field_end;
    logic       line_done;
    logic [7:0] field_total;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata_o;
  logic                    pready_o;

  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_byte = 8'h00;

  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic       content_valid_o;
  logic [7:0] content_byte_o;
  logic [7:0] field_index_o;
  logic       field_end_o;
  logic       line_done_o;
  logic [7:0] field_total_o;

  // Predictor state: a private copy of the parser and its limit register
  parse_phase_e line_phase = PH_START;
  logic [7:0]   fields_done = 8'd0;
  logic [7:0]   limit_reg = FieldLimitReset;

  token_t expected_tokens[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int lines_checked = 0;
  int field_ends_checked = 0;
  int content_checked = 0;
  int unsigned cycle_count = 0;

  csv_field_tokenizer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .content_valid_o(content_valid_o),
    .content_byte_o (content_byte_o),
    .field_index_o  (field_index_o),
    .field_end_o    (field_end_o),
    .line_done_o    (line_done_o),
    .field_total_o  (field_total_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends a run that hangs.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("csv_field_tokenizer regression: fail");
    $finish;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    if (error_count < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
    end
    error_count++;
  endtask

  // A field finishes at the current byte.
  function automatic token_t close_field();
    token_t r;
    r = '0;
    r.field_end = 1'b1;
    r.field_index = fields_done;
    fields_done = fields_done + 8'd1;
    return r;
  endfunction

  function automatic token_t content_token(input logic [7:0] c);
    token_t r;
    r = '0;
    r.content_valid = 1'b1;
    r.content_byte = c;
    r.field_index = fields_done;
    return r;
  endfunction

  // Works out the result of one accepted byte and advances the parser copy.
  function automatic token_t tokenize_byte(input logic [7:0] c);
    token_t r;
    logic   blank;
    logic   eol;
    r = '0;
    blank = (c == CharSpace) || (c == CharTab);
    eol = (c == CharLf) || (c == CharCr);
    if (c == CharNul) begin
      // The terminator ends an open field, or an empty one after blanks.
      if (line_phase == PH_QUOTED || line_phase == PH_UNQUOTED ||
          (line_phase == PH_START_BLANK && fields_done < limit_reg)) begin
        r = close_field();
      end
      r.line_done = 1'b1;
      r.field_total = fields_done;
      line_phase = PH_START;
      fields_done = 8'd0;
    end else begin
      case (line_phase)
        PH_QUOTED: begin
          if (c == CharQuote) begin
            r = close_field();
            line_phase = PH_POSTQUOTE;
          end else begin
            r = content_token(c);
          end
        end
        PH_UNQUOTED: begin
          if (c == CharComma || eol) begin
            r = close_field();
            line_phase = PH_START;
          end else begin
            r = content_token(c);
          end
        end
        PH_START, PH_START_BLANK, PH_POSTQUOTE: begin
          // The limit is only looked at where a new field could begin.
          if (fields_done >= limit_reg) begin
            line_phase = PH_STOPPED;
          end else if (line_phase == PH_POSTQUOTE && (c == CharComma || blank)) begin
            // Separators after a closing quote are swallowed.
          end else if (blank) begin
            line_phase = PH_START_BLANK;
          end else if (c == CharQuote) begin
            line_phase = PH_QUOTED;
          end else if (c == CharComma) begin
            r = close_field();
            line_phase = PH_START;
          end else if (eol) begin
            r = close_field();
            line_phase = PH_STOPPED;
          end else begin
            r = content_token(c);
            line_phase = PH_UNQUOTED;
          end
        end
        default: begin
          line_phase = PH_STOPPED;
        end
      endcase
    end
    return r;
  endfunction

  // Sends one byte as a request, records its expected result, then maybe idles.
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    char_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_tokens.push_back(tokenize_byte(b));
    bytes_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CharNul);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes field_limit over the configuration port; only called when idle.
  task automatic write_field_limit(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FieldLimitAddr;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = value;
  endtask

  // Compares each result leaving the block with the oldest expectation.
  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got = {content_valid_o, content_byte_o, field_index_o,
               field_end_o, line_done_o, field_total_o};
        if (expected_tokens.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (got.content_valid !== want.content_valid)
            report_mismatch("content_valid", got.content_valid, want.content_valid);
          if (got.content_byte !== want.content_byte)
            report_mismatch("content_byte", got.content_byte, want.content_byte);
          if (got.field_index !== want.field_index)
            report_mismatch("field_index", got.field_index, want.field_index);
          if (got.field_end !== want.field_end)
            report_mismatch("field_end", got.field_end, want.field_end);
          if (got.line_done !== want.line_done)
            report_mismatch("line_done", got.line_done, want.line_done);
          if (got.field_total !== want.field_total)
            report_mismatch("field_total", got.field_total, want.field_total);
          if (want.line_done) lines_checked++;
          if (want.field_end) field_ends_checked++;
          if (want.content_valid) content_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hand-picked lines for every parsing rule at the reset limit.
  task automatic test_directed_lines();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Blanks, content, quoted comma, swallowed separators, CR end, LF at start.
    send_line(" \t1,\"q,\" ,,b\r\nx");
    // Unclosed quote, blank before terminator, bare terminator, closed quote.
    send_line("\"u");
    send_line(" ");
    send_byte(CharNul);
    send_line("\"\"");
    // Extreme content bytes.
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CharNul);
    drain_results();
  endtask

  // Limit extremes, the out-of-range zero and changes in the middle of a line.
  task automatic test_field_limit();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    write_field_limit(8'd1);
    send_line("a,b,c");
    send_line(" ");
    drain_results();
    write_field_limit(8'd0);
    send_line("x, ");
    send_line(" ");
    drain_results();
    // Fill a line past the largest limit.
    write_field_limit(8'd255);
    repeat (256) send_byte(CharComma);
    send_byte(CharNul);
    // Limit lowered between fields: the next field is never started.
    send_text("a,b,");
    drain_results();
    write_field_limit(8'd2);
    send_line("c");
    drain_results();
    // Limit reached while blanks wait at a field start.
    write_field_limit(8'd255);
    send_text("a, ");
    drain_results();
    write_field_limit(8'd1);
    send_byte(CharNul);
    drain_results();
    // A field already begun completes despite the limit.
    write_field_limit(8'd255);
    send_text("a,\"b");
    drain_results();
    write_field_limit(8'd1);
    send_line("c\"");
    drain_results();
  endtask

  // A byte that is neither a separator, a quote, a blank, an end of line nor zero.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CharQuote || b == CharComma || b == CharSpace ||
               b == CharTab || b == CharLf || b == CharCr);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(1) ? CharSpace : CharTab;
  endfunction

  // One line, mostly well formed with random content, sometimes pure noise.
  task automatic send_random_line();
    int         n_fields;
    int         ending;
    logic [7:0] b;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
    end else begin
      n_fields = $urandom_range(6);
      for (int f = 0; f < n_fields; f++) begin
        repeat ($urandom_range(2)) send_byte(blank_byte());
        case ($urandom_range(3))
          0: repeat ($urandom_range(1, 6)) send_byte(plain_byte());
          1: begin
            send_byte(CharQuote);
            repeat ($urandom_range(5)) begin
              do b = 8'($urandom_range(1, 255)); while (b == CharQuote);
              send_byte(b);
            end
            if ($urandom_range(3) != 0) send_byte(CharQuote);
            repeat ($urandom_range(2)) send_byte($urandom_range(1) ? CharComma : blank_byte());
          end
          2: begin
            // Empty field: the separator alone.
          end
          default: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
        endcase
        if (f < n_fields - 1) send_byte(CharComma);
      end
      ending = $urandom_range(7);
      if (ending == 0) begin
        send_byte($urandom_range(1) ? CharCr : CharLf);
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(1, 255)));
      end else if (ending == 1) begin
        send_byte(blank_byte());
      end else if (ending == 2) begin
        send_byte(CharLf);
      end
    end
    send_byte(CharNul);
  endtask

  // Random lines under one idle pattern and one field limit.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [7:0] limit, input int count);
    int start_count;
    write_field_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < count) begin
      send_random_line();
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_field_limit();
    test_random_traffic(24, 84, 8'($urandom_range(1, 4)), 370);
    test_random_traffic(84, 24, 8'd255, 370);
    test_random_traffic(0, 0, 8'($urandom_range(1, 255)), 370);
    $display("Covered %0d bytes over %0d lines under several field limits and idle patterns;",
             bytes_sent, lines_checked);
    $display("checked %0d field ends and %0d content bytes, %0d mismatches.",
             field_ends_checked, content_checked, error_count);
    if (error_count == 0) begin
      $display("csv_field_tokenizer regression: pass");
    end else begin
      $display("csv_field_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
